/* rtl/lhp_pkg.sv */
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types and constants for the latency histogram percentile block.
// ----------------------------------------------------------------------------
package lhp_pkg;

   localparam int NUM_BINS_DEF     = 101;
   localparam int BIN_WIDTH_US_DEF = 1000;

   localparam logic [1:0] ACT_RECORD = 2'd0;
   localparam logic [1:0] ACT_REPORT = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] KIND_BASE  = 2'd0;
   localparam logic [1:0] KIND_AUDIO = 2'd1;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   // floor(x / 5) = (x * RANK_Q_MUL) >> RANK_Q_SHIFT for any 30-bit x
   localparam logic [31:0] RANK_Q_MUL   = 32'd1717986919;
   localparam int          RANK_Q_SHIFT = 33;
   localparam int          RANK_Q_W     = 29;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  source_kind;
      logic [63:0] stamp_us;
      logic [63:0] now_us;
   } req_type;

   typedef struct packed {
      logic        counted;
      logic [31:0] base_total;
      logic [31:0] audio_total;
      logic [6:0]  base_median_ms;
      logic [6:0]  base_p95_ms;
      logic [6:0]  audio_median_ms;
      logic [6:0]  audio_p95_ms;
   } rsp_type;

endpackage

/* rtl/latency_histogram_percentile_top.sv */
// ----------------------------------------------------------------------------
// latency_histogram_percentile_top
// Two latency histograms in one shared memory, with record, report and clear.
// ----------------------------------------------------------------------------
// Usage:
//   An input word on req_word is taken when start is high and busy is low.
//   One response word per input appears on rsp_word, flagged by rsp_strobe
//   for a single cycle; the receiver cannot stall, so it must sample it.
//   Both histograms share one memory word per bin ({audio, base}), read
//   through a register, so a record reads its bin and then writes it back.
//   Steps from accept to strobe (the strobe is registered):
//     record                  diff, divide, read, write back
//     record that is ignored  diff, divide, then the response
//     report                  diff, rank, setup, walk, drain (one bin read per cycle)
//     clear                   diff, then zeroing (one bin zeroed per cycle)
//     unused action           diff, then the response
//   One item is in flight at a time; busy is low again in the strobe cycle,
//   so a new word can be taken there.
//   After reset the block zeroes every memory bin, with busy high and
//   no response; counts reset to zero at once.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_top #(
   parameter int NUM_BINS     = lhp_pkg::NUM_BINS_DEF,
   parameter int BIN_WIDTH_US = lhp_pkg::BIN_WIDTH_US_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lhp_pkg::req_type req_word,
   output logic             rsp_strobe,
   output lhp_pkg::rsp_type rsp_word
);

   localparam int AW        = $clog2(NUM_BINS);
   localparam int DW        = $clog2(NUM_BINS * BIN_WIDTH_US);
   localparam int BIN_SHIFT = DW + $clog2(BIN_WIDTH_US);
   localparam int MW        = DW + 2;
   localparam int PW        = DW + MW;
   localparam int ACW       = 32 + AW;
   localparam logic [63:0] BIN_LIMIT = 64'(NUM_BINS) * 64'(BIN_WIDTH_US);
   localparam logic [63:0] BIN_MUL64 =
      ((64'd1 << BIN_SHIFT) + 64'(BIN_WIDTH_US) - 64'd1) / 64'(BIN_WIDTH_US);
   localparam logic [MW-1:0] BIN_MUL  = BIN_MUL64[MW-1:0];
   localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIFF, S_BIN, S_READ, S_WRITE, S_RANK, S_SETUP, S_WALK, S_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             clr_reply_ff, clr_reply_in;
   logic             data_vld_ff, data_vld_in;
   logic [31:0]      base_count_ff, base_count_in;
   logic [31:0]      audio_count_ff, audio_count_in;
   logic [3:0]       found_ff, found_in;

   lhp_pkg::req_type req_ff, req_in;
   lhp_pkg::rsp_type rsp_ff, rsp_in;
   logic [63:0]      diff_ff, diff_in;
   logic             ok_ff, ok_in;
   logic             long_ff, long_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [AW-1:0]    bin_ff, bin_in;
   logic [61:0]      prod_b_ff, prod_b_in;
   logic [61:0]      prod_a_ff, prod_a_in;
   logic [31:0]      rank_ff [4];
   logic [31:0]      rank_in [4];
   logic [ACW-1:0]   acc_b_ff, acc_b_in;
   logic [ACW-1:0]   acc_a_ff, acc_a_in;
   logic [AW-1:0]    pick_ff [4];
   logic [AW-1:0]    pick_in [4];
   logic [AW-1:0]    data_idx_ff, data_idx_in;

   logic [63:0]      hist_mem [NUM_BINS];
   logic [63:0]      mem_q_ff;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [63:0]      mem_wdata;

   logic [64:0]      sub_full;
   logic [AW-1:0]    bin_sel;
   logic [ACW-1:0]   sum_sel;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == lhp_pkg::SAT32) ? v : v + 32'd1;
   endfunction

   function automatic logic [6:0] pct7(input logic [AW-1:0] idx);
      logic [AW+6:0] ext;
      ext = {7'd0, idx};
      return ext[6:0];
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= hist_mem[mem_raddr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      rsp_strobe_in  = 1'b0;
      clr_reply_in   = clr_reply_ff;
      data_vld_in    = 1'b0;
      base_count_in  = base_count_ff;
      audio_count_in = audio_count_ff;
      found_in       = found_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      diff_in        = diff_ff;
      ok_in          = ok_ff;
      long_in        = long_ff;
      prod_in        = prod_ff;
      bin_in         = bin_ff;
      prod_b_in      = prod_b_ff;
      prod_a_in      = prod_a_ff;
      rank_in        = rank_ff;
      acc_b_in       = acc_b_ff;
      acc_a_in       = acc_a_ff;
      pick_in        = pick_ff;
      data_idx_in    = data_idx_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = addr_ff;
      mem_raddr      = addr_ff;
      mem_wdata      = 64'd0;
      sub_full       = {1'b0, req_ff.now_us} - {1'b0, req_ff.stamp_us};
      bin_sel        = long_ff ? LAST_BIN : prod_ff[BIN_SHIFT +: AW];
      sum_sel        = '0;

      // accumulate the bin read in the previous cycle
      if (data_vld_ff) begin
         acc_b_in = acc_b_ff + ACW'(mem_q_ff[31:0]);
         acc_a_in = acc_a_ff + ACW'(mem_q_ff[63:32]);
         for (int k = 0; k < 4; k++) begin
            sum_sel = (k < 2) ? acc_b_in : acc_a_in;
            if (!found_ff[k] && sum_sel >= ACW'(rank_ff[k])) begin
               found_in[k] = 1'b1;
               pick_in[k]  = data_idx_ff;
            end
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            addr_in   = addr_ff + AW'(1);
            if (addr_ff == LAST_BIN) begin
               addr_in       = '0;
               state_in      = S_IDLE;
               rsp_strobe_in = clr_reply_ff;
               rsp_in        = '0;
               clr_reply_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in = sub_full[63:0];
            ok_in   = (req_ff.stamp_us != 64'd0) && !sub_full[64]
                      && (req_ff.source_kind == lhp_pkg::KIND_BASE
                          || req_ff.source_kind == lhp_pkg::KIND_AUDIO);
            case (req_ff.action)
               lhp_pkg::ACT_RECORD: state_in = S_BIN;
               lhp_pkg::ACT_REPORT: state_in = S_RANK;
               lhp_pkg::ACT_CLEAR: begin
                  base_count_in  = 32'd0;
                  audio_count_in = 32'd0;
                  clr_reply_in   = 1'b1;
                  addr_in        = '0;
                  state_in       = S_CLEAR;
               end
               default: begin
                  rsp_in             = '0;
                  rsp_in.base_total  = base_count_ff;
                  rsp_in.audio_total = audio_count_ff;
                  rsp_strobe_in      = 1'b1;
                  state_in           = S_IDLE;
               end
            endcase
         end
         S_BIN: begin
            long_in = (diff_ff >= BIN_LIMIT);
            prod_in = PW'(diff_ff[DW-1:0]) * PW'(BIN_MUL);
            if (ok_ff) begin
               state_in = S_READ;
            end else begin
               rsp_in             = '0;
               rsp_in.base_total  = base_count_ff;
               rsp_in.audio_total = audio_count_ff;
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_READ: begin
            mem_re    = 1'b1;
            mem_raddr = bin_sel;
            bin_in    = bin_sel;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = bin_ff;
            if (req_ff.source_kind == lhp_pkg::KIND_BASE) begin
               mem_wdata     = {mem_q_ff[63:32], sat_inc(mem_q_ff[31:0])};
               base_count_in = sat_inc(base_count_ff);
            end else begin
               mem_wdata      = {sat_inc(mem_q_ff[63:32]), mem_q_ff[31:0]};
               audio_count_in = sat_inc(audio_count_ff);
            end
            rsp_in             = '0;
            rsp_in.counted     = 1'b1;
            rsp_in.base_total  = base_count_in;
            rsp_in.audio_total = audio_count_in;
            rsp_strobe_in      = 1'b1;
            state_in           = S_IDLE;
         end
         S_RANK: begin
            // ceil(0.95 * c) = c - floor(c / 20)
            prod_b_in = 62'(base_count_ff[31:2]) * 62'(lhp_pkg::RANK_Q_MUL);
            prod_a_in = 62'(audio_count_ff[31:2]) * 62'(lhp_pkg::RANK_Q_MUL);
            state_in  = S_SETUP;
         end
         S_SETUP: begin
            rank_in[0] = base_count_ff - {1'b0, base_count_ff[31:1]};
            rank_in[1] = base_count_ff
                         - 32'(prod_b_ff[lhp_pkg::RANK_Q_SHIFT +: lhp_pkg::RANK_Q_W]);
            rank_in[2] = audio_count_ff - {1'b0, audio_count_ff[31:1]};
            rank_in[3] = audio_count_ff
                         - 32'(prod_a_ff[lhp_pkg::RANK_Q_SHIFT +: lhp_pkg::RANK_Q_W]);
            acc_b_in   = '0;
            acc_a_in   = '0;
            found_in   = 4'd0;
            for (int k = 0; k < 4; k++) begin
               pick_in[k] = LAST_BIN;
            end
            addr_in  = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            mem_re      = 1'b1;
            mem_raddr   = addr_ff;
            data_vld_in = 1'b1;
            data_idx_in = addr_ff;
            addr_in     = addr_ff + AW'(1);
            if (addr_ff == LAST_BIN) begin
               addr_in  = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            rsp_in                 = '0;
            rsp_in.base_total      = base_count_ff;
            rsp_in.audio_total     = audio_count_ff;
            rsp_in.base_median_ms  = pct7(pick_in[0]);
            rsp_in.base_p95_ms     = pct7(pick_in[1]);
            rsp_in.audio_median_ms = pct7(pick_in[2]);
            rsp_in.audio_p95_ms    = pct7(pick_in[3]);
            rsp_strobe_in          = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      diff_ff     <= diff_in;
      ok_ff       <= ok_in;
      long_ff     <= long_in;
      prod_ff     <= prod_in;
      bin_ff      <= bin_in;
      prod_b_ff   <= prod_b_in;
      prod_a_ff   <= prod_a_in;
      rank_ff     <= rank_in;
      acc_b_ff    <= acc_b_in;
      acc_a_ff    <= acc_a_in;
      pick_ff     <= pick_in;
      data_idx_ff <= data_idx_in;
      if (reset) begin
         state_ff       <= S_CLEAR;
         addr_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
         clr_reply_ff   <= 1'b0;
         data_vld_ff    <= 1'b0;
         base_count_ff  <= 32'd0;
         audio_count_ff <= 32'd0;
         found_ff       <= 4'd0;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         clr_reply_ff   <= clr_reply_in;
         data_vld_ff    <= data_vld_in;
         base_count_ff  <= base_count_in;
         audio_count_ff <= audio_count_in;
         found_ff       <= found_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("response strobe high two cycles in a row");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE))
      else $error("response shown while an item is still in progress");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WRITE && state_ff != S_DIFF)
      |=> ($stable(base_count_ff) && $stable(audio_count_ff)))
      else $error("sample count changed outside record or clear");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= LAST_BIN)
      else $error("bin address beyond last bin");

   a_drain_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> data_vld_ff)
      else $error("last bin of the walk not read");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the latency histogram percentile block: record, report and
// clear words go in through the start/busy handshake, and every response word
// is compared field by field with a local model of the two histograms or with
// a pinned answer. A short directed pass covers empty reports, ignored
// samples, extreme timestamps and the unused action. A long random pass
// follows with clustered delays, so that the percentiles move around.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BINS           = lhp_pkg::NUM_BINS_DEF;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int CALM_TAIL      = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [1:0] ACT_SPARE  = 2'd3;
   localparam logic [1:0] KIND_OTHER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [63:0] ALL_ONES = '1;

   typedef struct packed {
      lhp_pkg::req_type word;
      logic             pinned;
      lhp_pkg::rsp_type answer;
   } step_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   lhp_pkg::req_type req_word;
   logic             rsp_strobe;
   lhp_pkg::rsp_type rsp_word;

   logic [31:0] hist_bins [2][BINS];
   logic [31:0] hist_total [2];

   lhp_pkg::rsp_type stats_due [$];
   step_type         opening_steps [$];

   int errors       = 0;
   int quiet_cycles = 0;
   int n_counted    = 0;
   int n_ignored    = 0;
   int n_reports    = 0;
   int n_clears     = 0;
   int n_spare      = 0;

   latency_histogram_percentile_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_histograms();
      for (int i = 0; i < BINS; i++) begin
         hist_bins[0][i] = '0;
         hist_bins[1][i] = '0;
      end
      hist_total[0] = '0;
      hist_total[1] = '0;
   endfunction

   function automatic logic [6:0] percentile_bin(input int side, input int pct);
      logic [63:0] rank;
      logic [63:0] acc;
      if (hist_total[side] == 0)
         return '0;
      rank = (64'(hist_total[side]) * 64'(pct) + 64'd99) / 64'd100;
      acc = '0;
      for (int i = 0; i < BINS; i++) begin
         acc = acc + 64'(hist_bins[side][i]);
         if (acc >= rank)
            return 7'(i);
      end
      return 7'(BINS - 1);
   endfunction

   function automatic lhp_pkg::rsp_type apply_to_histograms(input lhp_pkg::req_type w);
      lhp_pkg::rsp_type r;
      logic [63:0]      bin;
      int               side;
      r = '0;
      side = (w.source_kind == lhp_pkg::KIND_AUDIO) ? 1 : 0;
      case (w.action)
         lhp_pkg::ACT_RECORD: begin
            if (w.stamp_us != 0 && w.now_us >= w.stamp_us &&
                (w.source_kind == lhp_pkg::KIND_BASE ||
                 w.source_kind == lhp_pkg::KIND_AUDIO)) begin
               bin = (w.now_us - w.stamp_us) / 64'(lhp_pkg::BIN_WIDTH_US_DEF);
               if (bin > 64'(BINS - 1))
                  bin = 64'(BINS - 1);
               if (hist_bins[side][int'(bin)] != lhp_pkg::SAT32)
                  hist_bins[side][int'(bin)]++;
               if (hist_total[side] != lhp_pkg::SAT32)
                  hist_total[side]++;
               r.counted = 1'b1;
            end
         end
         lhp_pkg::ACT_REPORT: begin
            r.base_median_ms  = percentile_bin(0, 50);
            r.base_p95_ms     = percentile_bin(0, 95);
            r.audio_median_ms = percentile_bin(1, 50);
            r.audio_p95_ms    = percentile_bin(1, 95);
         end
         lhp_pkg::ACT_CLEAR: begin
            clear_histograms();
         end
         default: begin
         end
      endcase
      r.base_total  = hist_total[0];
      r.audio_total = hist_total[1];
      return r;
   endfunction

   function automatic int field_diff(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic add_row(input logic [1:0] action, input logic [1:0] kind,
                          input logic [63:0] stamp, input logic [63:0] now,
                          input logic pinned, input logic counted,
                          input logic [31:0] base_n, input logic [31:0] audio_n);
      step_type s;
      s = '0;
      s.word.action      = action;
      s.word.source_kind = kind;
      s.word.stamp_us    = stamp;
      s.word.now_us      = now;
      s.pinned           = pinned;
      s.answer.counted     = counted;
      s.answer.base_total  = base_n;
      s.answer.audio_total = audio_n;
      opening_steps.push_back(s);
   endtask

   // hold start until the word is taken, then queue what it must return
   task automatic issue(input lhp_pkg::req_type w, input logic pinned,
                        input lhp_pkg::rsp_type answer);
      lhp_pkg::rsp_type due;
      req_word <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      due = apply_to_histograms(w);
      stats_due.push_back(pinned ? answer : due);
      case (w.action)
         lhp_pkg::ACT_RECORD: if (due.counted) n_counted++; else n_ignored++;
         lhp_pkg::ACT_REPORT: n_reports++;
         lhp_pkg::ACT_CLEAR:  n_clears++;
         default:             n_spare++;
      endcase
   endtask

   task automatic maybe_pause(input bit allowed);
      if (allowed && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8))
            @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      lhp_pkg::rsp_type want;
      if (rsp_strobe === 1'b1) begin
         if (stats_due.size() == 0) begin
            $display("%0t ns: unexpected word %h", $time, rsp_word);
            errors++;
         end else begin
            want = stats_due.pop_front();
            errors += field_diff("counted", 64'(want.counted), 64'(rsp_word.counted))
                    + field_diff("base_total", 64'(want.base_total),
                                 64'(rsp_word.base_total))
                    + field_diff("audio_total", 64'(want.audio_total),
                                 64'(rsp_word.audio_total))
                    + field_diff("base_median_ms", 64'(want.base_median_ms),
                                 64'(rsp_word.base_median_ms))
                    + field_diff("base_p95_ms", 64'(want.base_p95_ms),
                                 64'(rsp_word.base_p95_ms))
                    + field_diff("audio_median_ms", 64'(want.audio_median_ms),
                                 64'(rsp_word.audio_median_ms))
                    + field_diff("audio_p95_ms", 64'(want.audio_p95_ms),
                                 64'(rsp_word.audio_p95_ms));
         end
      end
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      lhp_pkg::req_type w;
      logic [63:0]      span;
      int               pick;
      int               center;
      bit               idle_on;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;
      clear_histograms();

      add_row(lhp_pkg::ACT_REPORT, lhp_pkg::KIND_BASE, 64'd0, 64'd0, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd0, 64'd5000, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd9000, 64'd8999, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, KIND_OTHER, 64'd1, 64'd2000, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, KIND_SPARE, 64'd1, 64'd2000, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, ALL_ONES, 64'd0, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd1, 64'd1, 1, 1, 1, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_AUDIO, 64'd1000, ALL_ONES, 1, 1, 1, 1);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, ALL_ONES, ALL_ONES, 1, 1, 2, 1);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_AUDIO, 64'd5, 64'd100004, 1, 1, 2, 2);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd7, 64'd100007, 1, 1, 3, 2);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd1, 64'd1000, 1, 1, 4, 2);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd1, 64'd1001, 1, 1, 5, 2);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_AUDIO, 64'd2, 64'd50502, 1, 1, 5, 3);
      add_row(lhp_pkg::ACT_REPORT, KIND_SPARE, ALL_ONES, ALL_ONES, 0, 0, 0, 0);
      add_row(ACT_SPARE, KIND_SPARE, {$urandom, $urandom}, {$urandom, $urandom},
              1, 0, 5, 3);
      add_row(lhp_pkg::ACT_CLEAR, KIND_OTHER, {$urandom, $urandom},
              {$urandom, $urandom}, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_REPORT, lhp_pkg::KIND_AUDIO, 64'd0, 64'd0, 1, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_AUDIO, 64'd40, 64'd3040, 1, 1, 0, 1);
      add_row(lhp_pkg::ACT_REPORT, lhp_pkg::KIND_BASE, 64'd0, 64'd0, 0, 0, 0, 0);
      add_row(lhp_pkg::ACT_RECORD, lhp_pkg::KIND_BASE, 64'd1, ALL_ONES, 1, 1, 1, 1);
      add_row(lhp_pkg::ACT_REPORT, lhp_pkg::KIND_BASE, 64'd0, 64'd0, 0, 0, 0, 0);
      add_row(lhp_pkg::ACT_CLEAR, lhp_pkg::KIND_BASE, 64'd0, 64'd0, 1, 0, 0, 0);

      repeat (12)
         @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < opening_steps.size(); n++) begin
         issue(opening_steps[n].word, opening_steps[n].pinned, opening_steps[n].answer);
         maybe_pause(1'b1);
      end

      center = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            center = $urandom_range(0, BINS - 1);
         idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 150) % 3 != 2);
         pick = $urandom_range(0, 99);
         w.action      = lhp_pkg::ACT_RECORD;
         w.source_kind = 2'($urandom_range(0, 1));
         w.stamp_us    = {$urandom, $urandom};
         w.now_us      = {$urandom, $urandom};
         if (pick < 78) begin
            if ($urandom_range(0, 9) == 0) begin
               w.stamp_us     = {32'd0, $urandom} | 64'd1;
               w.now_us[63]   = 1'b1;
            end else begin
               if ($urandom_range(0, 2) == 0)
                  span = 64'(center) * 64'd1000 + 64'($urandom_range(0, 2999));
               else
                  span = 64'($urandom_range(0, 101999));
               if (w.now_us <= span)
                  w.now_us = w.now_us + span + 64'd1;
               w.stamp_us = w.now_us - span;
            end
         end else if (pick < 86) begin
            case ($urandom_range(0, 2))
               0: w.stamp_us = '0;
               1: begin
                  w.now_us[63] = 1'b0;
                  w.stamp_us   = w.now_us + 64'd1 + 64'($urandom_range(0, 1000));
               end
               default: begin
                  w.source_kind = 2'($urandom_range(2, 3));
                  w.now_us[63]  = 1'b1;
                  w.stamp_us    = w.now_us - 64'($urandom_range(0, 200000));
               end
            endcase
         end else begin
            w.source_kind = 2'($urandom_range(0, 3));
            if (pick < 96)
               w.action = lhp_pkg::ACT_REPORT;
            else if (pick < 98)
               w.action = lhp_pkg::ACT_CLEAR;
            else
               w.action = ACT_SPARE;
         end
         issue(w, 1'b0, '0);
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            while (stats_due.size() != 0)
               @(posedge clock);
         end else begin
            maybe_pause(idle_on);
         end
      end

      start <= 1'b0;
      while (stats_due.size() != 0)
         @(posedge clock);
      repeat (BINS + 10)
         @(posedge clock);

      $display("Sent %0d words: %0d samples counted, %0d ignored, %0d reports,",
               n_counted + n_ignored + n_reports + n_clears + n_spare,
               n_counted, n_ignored, n_reports);
      $display("%0d clears, %0d unused actions; %0d field mismatches",
               n_clears, n_spare, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/lhp_pkg.sv
rtl/latency_histogram_percentile_top.sv
verif/tb_top.sv
